[src/assert_macros.svh]
// assertion macros shared by the timer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check on every clock edge out of reset
`define AST_HOLD(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/imt_pkg.sv]
// package: shared types and constants of the interval multi-timer
package imt_pkg;

    localparam int SLOTS_DEF     = 8;
    localparam int TICK_STEP_DEF = 10;
    localparam int ID_W          = 16;
    localparam int PER_W         = 24;
    localparam logic [PER_W-1:0] WRAP_AT = 24'd10000000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_KILL  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_IV = 2'd1,
        ST_FULL   = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DIV,
        S_UPD,
        S_WRAP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic slot_upd;
        logic wrap;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic slot_live;
        logic tc_zero;
        logic div_done;
        logic emit_last;
    } dp_stat_t;

endpackage

[src/imt_div.sv]
// remainder unit: restoring division, one bit per cycle
`include "assert_macros.svh"
module imt_div
    import imt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [PER_W-1:0] dividend,
    input  logic [PER_W-1:0] divisor,
    output logic [PER_W-1:0] rem,
    output logic             done
);

    localparam int CW = $clog2(PER_W + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [PER_W-1:0] rem_reg, rem_next;
    logic [PER_W-1:0] dvd_reg, dvd_next;
    logic [PER_W:0]   trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        trial     = {rem_reg, dvd_reg[PER_W-1]};
        if (start)
        begin
            cnt_next = CW'(PER_W);
            rem_next = '0;
            dvd_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = PER_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[PER_W-1:0];
            end
            dvd_next = {dvd_reg[PER_W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

    `AST_IMP(a_done_idle, done_reg, cnt_reg == '0, "remainder done while still shifting")

endmodule

[src/imt_ctrl.sv]
// controller: sequences load, execute, slot walk, counter wrap and result emission
module imt_ctrl
    import imt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = (stat.op == OP_TICK) ? S_SCAN : S_EMIT;
            end
            S_SCAN:
            begin
                if (!stat.slot_live)
                begin
                    state_next = S_WRAP;
                end
                else if (!stat.tc_zero)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:  state_next = S_SCAN;
            S_WRAP: state_next = S_EMIT;
            S_EMIT:
            begin
                if (stat.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_EXEC: cmd.exec = 1'b1;
            S_SCAN:
            begin
                cmd.slot_upd  = stat.slot_live && stat.tc_zero;
                cmd.div_start = stat.slot_live && !stat.tc_zero;
            end
            S_DIV:  cmd = '0;
            S_UPD:  cmd.slot_upd = 1'b1;
            S_WRAP: cmd.wrap = 1'b1;
            S_EMIT: cmd.emit = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/imt_dp.sv]
// datapath: slot table, counters, kill and insert logic, result buffer
`include "assert_macros.svh"
module imt_dp
    import imt_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TICK_STEP = TICK_STEP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    input  logic [1:0]       op,
    input  logic [ID_W-1:0]  timer_ids,
    input  logic [PER_W-1:0] interval,
    input  logic             once,
    output logic             strobe,
    output logic [ID_W-1:0]  fired_ids,
    output logic [ID_W-1:0]  active_ids,
    output logic [1:0]       status,
    output logic             last
);

    localparam int IW = $clog2(SLOTS + 1);

    op_t              op_reg;
    logic [ID_W-1:0]  idin_reg;
    logic [PER_W-1:0] iv_reg;
    logic             once_reg;

    logic [PER_W-1:0] per_reg [SLOTS];
    logic [PER_W-1:0] per_next [SLOTS];
    logic [ID_W-1:0]  ids_reg [SLOTS];
    logic [ID_W-1:0]  ids_next [SLOTS];
    logic [SLOTS-1:0] used_reg, used_next;
    logic [ID_W-1:0]  one_reg, one_next;
    logic [ID_W-1:0]  live_reg, live_next;
    logic [PER_W-1:0] tc_reg, tc_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    nres_reg, nres_next;
    logic [IW-1:0]    eidx_reg, eidx_next;
    stat_t            st_reg, st_next;

    logic [ID_W-1:0]  fbuf_reg [SLOTS];

    logic             strobe_reg, strobe_next;
    logic [ID_W-1:0]  fout_reg, fout_next;
    logic [ID_W-1:0]  aout_reg, aout_next;
    logic             last_reg, last_next;

    logic [ID_W-1:0]  k_ids [SLOTS];
    logic [ID_W-1:0]  k_one, k_live, kmask;
    logic             k_found;
    logic [PER_W-1:0] cur_per;
    logic [ID_W-1:0]  cur_ids, cur_kids, fbuf_rd;
    logic             cur_used, fire, rec;
    logic [SLOTS-1:0] first_v, after_v;
    logic             seen, match, full;
    logic [PER_W-1:0] prev_per;
    logic [ID_W-1:0]  prev_ids;
    logic             prev_used;
    logic [PER_W-1:0] div_rem;
    logic             div_done;
    logic             emit_last;
    logic [SLOTS:0]   used_p1;

    imt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (tc_reg),
        .divisor  (cur_per),
        .rem      (div_rem),
        .done     (div_done)
    );

    // slot under the walk pointer, and result buffer entry under the emit pointer
    always_comb
    begin
        cur_per  = '0;
        cur_ids  = '0;
        cur_kids = '0;
        cur_used = 1'b0;
        fbuf_rd  = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (idx_reg == IW'(j))
            begin
                cur_per  = per_reg[j];
                cur_ids  = ids_reg[j];
                cur_kids = k_ids[j];
                cur_used = used_reg[j];
            end
            if (eidx_reg == IW'(j))
            begin
                fbuf_rd = fbuf_reg[j];
            end
        end
    end

    assign fire      = !cmd.exec && (tc_reg != '0) && (div_rem == '0);
    assign rec       = fire && (cur_ids != '0) && (nres_reg < IW'(SLOTS));
    assign kmask     = (op_reg == OP_TICK) ? (fire ? (cur_ids & one_reg) : '0) : idin_reg;
    assign emit_last = (eidx_reg + IW'(1)) >= nres_reg;

    // kill: first used slot holding any of the ids
    always_comb
    begin
        k_found = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            k_ids[j] = ids_reg[j];
            if (!k_found && used_reg[j] && ((ids_reg[j] & kmask) != '0))
            begin
                k_ids[j] = ids_reg[j] & ~kmask;
                k_found  = 1'b1;
            end
        end
        k_one  = k_found ? (one_reg & ~kmask) : one_reg;
        k_live = used_reg[0] ? (live_reg & ~kmask) : live_reg;
    end

    // insert position for set
    always_comb
    begin
        seen  = 1'b0;
        match = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            after_v[j] = seen;
            first_v[j] = 1'b0;
            if (!seen && (!used_reg[j] || per_reg[j] >= iv_reg))
            begin
                first_v[j] = 1'b1;
                seen       = 1'b1;
                match      = used_reg[j] && (per_reg[j] == iv_reg);
            end
        end
        full = used_reg[SLOTS-1];
    end

    always_comb
    begin
        per_next  = per_reg;
        ids_next  = ids_reg;
        used_next = used_reg;
        one_next  = one_reg;
        live_next = live_reg;
        tc_next   = tc_reg;
        idx_next  = idx_reg;
        nres_next = nres_reg;
        eidx_next = eidx_reg;
        st_next   = st_reg;
        prev_per  = '0;
        prev_ids  = '0;
        prev_used = 1'b0;
        strobe_next = 1'b0;
        fout_next   = fout_reg;
        aout_next   = aout_reg;
        last_next   = last_reg;

        if (cmd.exec)
        begin
            idx_next  = '0;
            nres_next = '0;
            eidx_next = '0;
            st_next   = ST_OK;
            case (op_reg)
                OP_TICK:
                begin
                    tc_next = tc_reg + PER_W'(TICK_STEP);
                end
                OP_SET:
                begin
                    if (iv_reg == '0)
                    begin
                        st_next = ST_BAD_IV;
                    end
                    else if (!match && full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        for (int j = 0; j < SLOTS; j++)
                        begin
                            if (first_v[j])
                            begin
                                per_next[j]  = iv_reg;
                                used_next[j] = 1'b1;
                                ids_next[j]  = match ? (k_ids[j] | idin_reg) : idin_reg;
                            end
                            else if (after_v[j] && !match)
                            begin
                                per_next[j]  = prev_per;
                                ids_next[j]  = prev_ids;
                                used_next[j] = prev_used;
                            end
                            else
                            begin
                                ids_next[j] = k_ids[j];
                            end
                            prev_per  = per_reg[j];
                            prev_ids  = k_ids[j];
                            prev_used = used_reg[j];
                        end
                        one_next  = k_one | (once_reg ? idin_reg : '0);
                        live_next = k_live | idin_reg;
                        tc_next   = '0;
                    end
                end
                OP_KILL:
                begin
                    ids_next  = k_ids;
                    one_next  = k_one;
                    live_next = k_live;
                end
                OP_CLEAR:
                begin
                    for (int j = 0; j < SLOTS; j++)
                    begin
                        per_next[j] = '0;
                        ids_next[j] = '0;
                    end
                    used_next = '0;
                    one_next  = '0;
                    live_next = '0;
                    tc_next   = '0;
                end
                default: st_next = ST_OK;
            endcase
        end

        if (cmd.slot_upd)
        begin
            ids_next  = k_ids;
            one_next  = k_one;
            live_next = k_live;
            if (rec)
            begin
                nres_next = nres_reg + IW'(1);
            end
            if (cur_kids == '0)
            begin
                for (int j = 0; j < SLOTS - 1; j++)
                begin
                    if (IW'(j) >= idx_reg)
                    begin
                        per_next[j]  = per_reg[j+1];
                        ids_next[j]  = k_ids[j+1];
                        used_next[j] = used_reg[j+1];
                    end
                end
                per_next[SLOTS-1]  = '0;
                ids_next[SLOTS-1]  = '0;
                used_next[SLOTS-1] = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IW'(1);
            end
        end

        if (cmd.wrap && (tc_reg >= WRAP_AT))
        begin
            tc_next = '0;
        end

        if (cmd.emit)
        begin
            strobe_next = 1'b1;
            fout_next   = (nres_reg == '0) ? '0 : fbuf_rd;
            aout_next   = used_reg[0] ? live_reg : '0;
            last_next   = emit_last;
            eidx_next   = eidx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                per_reg[j] <= '0;
                ids_reg[j] <= '0;
            end
            used_reg   <= '0;
            one_reg    <= '0;
            live_reg   <= '0;
            tc_reg     <= '0;
            idx_reg    <= '0;
            nres_reg   <= '0;
            eidx_reg   <= '0;
            st_reg     <= ST_OK;
            strobe_reg <= 1'b0;
        end
        else
        begin
            per_reg    <= per_next;
            ids_reg    <= ids_next;
            used_reg   <= used_next;
            one_reg    <= one_next;
            live_reg   <= live_next;
            tc_reg     <= tc_next;
            idx_reg    <= idx_next;
            nres_reg   <= nres_next;
            eidx_reg   <= eidx_next;
            st_reg     <= st_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(op);
            idin_reg <= timer_ids;
            iv_reg   <= interval;
            once_reg <= once;
        end
        if (cmd.slot_upd && rec)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                if (nres_reg == IW'(j))
                begin
                    fbuf_reg[j] <= cur_ids;
                end
            end
        end
        fout_reg <= fout_next;
        aout_reg <= aout_next;
        last_reg <= last_next;
    end

    assign stat.op        = op_reg;
    assign stat.slot_live = (idx_reg < IW'(SLOTS)) && cur_used;
    assign stat.tc_zero   = (tc_reg == '0);
    assign stat.div_done  = div_done;
    assign stat.emit_last = emit_last;

    assign strobe     = strobe_reg;
    assign fired_ids  = fout_reg;
    assign active_ids = aout_reg;
    assign status     = st_reg;
    assign last       = last_reg;

    assign used_p1 = {1'b0, used_reg} + (SLOTS+1)'(1);

    `AST_HOLD(a_used_packed, $onehot(used_p1), "slot table lost its packing")
    `AST_IMP(a_nres_bound, 1'b1, nres_reg <= IW'(SLOTS), "result count past table size")
    `AST_IMP(a_walk_bound, cmd.slot_upd, idx_reg < IW'(SLOTS), "slot update past table end")

endmodule

[src/interval_multi_timer_core.sv]
// top level: interval multi-timer, controller plus datapath
//
//   channel   dir  handshake           fields
//   command   in   start & !busy       op, timer_ids, interval, once
//   result    out  strobe, one cycle   fired_ids, active_ids, status, last
//
// set, kill and clear pass from accept through execute to the single result
// a tick walks the slots and then emits its results; each live slot with a
// nonzero tick count is run through the bit-serial remainder unit
// busy stays high from accept until the last result reaches the ports
// results cannot be stalled; each is valid for the one cycle strobe is high
// reset is asynchronous, active low, and empties the slot table
`include "assert_macros.svh"
module interval_multi_timer_core
    import imt_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TICK_STEP = TICK_STEP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       op,
    input  logic [ID_W-1:0]  timer_ids,
    input  logic [PER_W-1:0] interval,
    input  logic             once,
    output logic             strobe,
    output logic [ID_W-1:0]  fired_ids,
    output logic [ID_W-1:0]  active_ids,
    output logic [1:0]       status,
    output logic             last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    imt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    imt_dp #(
        .SLOTS     (SLOTS),
        .TICK_STEP (TICK_STEP)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .timer_ids  (timer_ids),
        .interval   (interval),
        .once       (once),
        .strobe     (strobe),
        .fired_ids  (fired_ids),
        .active_ids (active_ids),
        .status     (status),
        .last       (last)
    );

    `AST_IMP(a_strobe_busy, strobe, $past(busy), "result without an item in flight")

endmodule

[dv/tb_top.sv]
// testbench for interval_multi_timer_core: random and directed commands
`timescale 1ns / 1ps

module tb_top;
    import imt_pkg::*;

    typedef struct {
        logic [ID_W-1:0] fired;
        logic [ID_W-1:0] active;
        logic [1:0]      stat;
        logic            fin;
    } timer_result_t;

    class timer_table_model;
        logic [PER_W-1:0] tcount;
        logic [PER_W-1:0] per [SLOTS_DEF];
        logic [ID_W-1:0]  sids [SLOTS_DEF];
        bit               used [SLOTS_DEF];
        logic [ID_W-1:0]  oneshot;
        logic [ID_W-1:0]  live;
        timer_result_t    expected_results[$];
        int               mismatches;

        function void clear_table();
            tcount = '0;
            oneshot = '0;
            live = '0;
            for (int i = 0; i < SLOTS_DEF; i++)
            begin
                per[i] = '0;
                sids[i] = '0;
                used[i] = 0;
            end
        endfunction

        function new();
            clear_table();
            mismatches = 0;
        endfunction

        function int used_slots();
            int n;
            n = 0;
            while (n < SLOTS_DEF && used[n])
                n++;
            return n;
        endfunction

        function void kill(logic [ID_W-1:0] ids);
            int n;
            n = used_slots();
            if (n == 0)
                return;
            for (int i = 0; i < n; i++)
            begin
                if ((sids[i] & ids) != 0)
                begin
                    sids[i] &= ~ids;
                    oneshot &= ~ids;
                    break;
                end
            end
            live &= ~ids;
        endfunction

        function void drop(int k);
            for (int i = k; i + 1 < SLOTS_DEF; i++)
            begin
                per[i] = per[i+1];
                sids[i] = sids[i+1];
                used[i] = used[i+1];
            end
            per[SLOTS_DEF-1] = '0;
            sids[SLOTS_DEF-1] = '0;
            used[SLOTS_DEF-1] = 0;
        endfunction

        function stat_t set_ids(logic [ID_W-1:0] ids, logic [PER_W-1:0] p, logic one);
            int n;
            int pos;
            n = used_slots();
            pos = 0;
            if (p == 0)
                return ST_BAD_IV;
            while (pos < n && per[pos] < p)
                pos++;
            if (!(pos < n && per[pos] == p))
            begin
                if (n >= SLOTS_DEF)
                    return ST_FULL;
                kill(ids);
                for (int i = n; i > pos; i--)
                begin
                    per[i] = per[i-1];
                    sids[i] = sids[i-1];
                    used[i] = used[i-1];
                end
                per[pos] = p;
                sids[pos] = '0;
                used[pos] = 1;
            end
            else
                kill(ids);
            sids[pos] |= ids;
            if (one)
                oneshot |= ids;
            tcount = '0;
            live |= ids;
            return ST_OK;
        endfunction

        function void note_command(op_t op, logic [ID_W-1:0] ids, logic [PER_W-1:0] p,
                                   logic one);
            logic [ID_W-1:0] fired[$];
            stat_t           st;
            logic [ID_W-1:0] act;
            logic [ID_W-1:0] f;
            int              i;
            timer_result_t   r;
            st = ST_OK;
            case (op)
                OP_TICK:
                begin
                    tcount = tcount + PER_W'(TICK_STEP_DEF);
                    i = 0;
                    while (i < SLOTS_DEF && used[i])
                    begin
                        if (tcount != 0 && (tcount % per[i]) == 0)
                        begin
                            f = sids[i];
                            if (f != 0)
                                fired = {fired, f};
                            if ((f & oneshot) != 0)
                                kill(f & oneshot);
                        end
                        if (sids[i] == 0)
                            drop(i);
                        else
                            i++;
                    end
                    if (tcount >= WRAP_AT)
                        tcount = '0;
                end
                OP_SET:   st = set_ids(ids, p, one);
                OP_KILL:  kill(ids);
                default:  clear_table();
            endcase
            if (fired.size() == 0)
                fired = {fired, ID_W'(0)};
            act = (used_slots() == 0) ? '0 : live;
            foreach (fired[k])
            begin
                r.fired = fired[k];
                r.active = act;
                r.stat = st;
                r.fin = (k == fired.size() - 1);
                expected_results = {expected_results, r};
            end
        endfunction

        function void check_result(logic [ID_W-1:0] fired, logic [ID_W-1:0] active,
                                   logic [1:0] stat, logic fin);
            timer_result_t e;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result fired=%h active=%h status=%0d last=%b",
                             fired, active, stat, fin);
                return;
            end
            e = expected_results.pop_front();
            if (fired !== e.fired || active !== e.active || stat !== e.stat || fin !== e.fin)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp %h %h %0d %b / got %h %h %0d %b",
                             e.fired, e.active, e.stat, e.fin, fired, active, stat, fin);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       op;
    logic [ID_W-1:0]  timer_ids;
    logic [PER_W-1:0] interval;
    logic             once;
    logic             strobe;
    logic [ID_W-1:0]  fired_ids;
    logic [ID_W-1:0]  active_ids;
    logic [1:0]       status;
    logic             last;

    timer_table_model timers;
    int               send_idle_pct;

    interval_multi_timer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .timer_ids  (timer_ids),
        .interval   (interval),
        .once       (once),
        .strobe     (strobe),
        .fired_ids  (fired_ids),
        .active_ids (active_ids),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            timers.check_result(fired_ids, active_ids, status, last);
    end

    task automatic issue(op_t o, logic [ID_W-1:0] ids, logic [PER_W-1:0] p, logic one);
        start <= 1'b1;
        op <= o;
        timer_ids <= ids;
        interval <= p;
        once <= one;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        timers.note_command(o, ids, p, one);
        if ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic random_item();
        int               r;
        logic [ID_W-1:0]  ids;
        logic [PER_W-1:0] p;
        r = $urandom_range(99);
        ids = ($urandom_range(1) != 0) ? ID_W'($urandom) : ID_W'($urandom & $urandom & $urandom);
        r = $urandom_range(99);
        p = PER_W'(10 * $urandom_range(1, 8));
        case ($urandom_range(19))
            0:       p = '0;
            1:       p = PER_W'($urandom_range(1, 10000000));
            2:       p = PER_W'($urandom_range(1, 100));
            default: ;
        endcase
        if (r < 45)
            issue(OP_TICK, ID_W'($urandom), PER_W'($urandom), 1'($urandom));
        else if (r < 80)
            issue(OP_SET, ids, p, 1'($urandom));
        else if (r < 96)
            issue(OP_KILL, ids, p, 1'($urandom));
        else
            issue(OP_CLEAR, ids, p, 1'($urandom));
    endtask

    initial
    begin
        int wait_cnt;
        timers = new();
        send_idle_pct = 12;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_TICK;
        timer_ids = '0;
        interval = '0;
        once = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        issue(OP_KILL, 16'hFFFF, '0, 1'b0);
        issue(OP_TICK, '0, '0, 1'b0);
        issue(OP_SET, 16'hFFFF, '0, 1'b1);
        issue(OP_SET, 16'hFFFF, 24'd10, 1'b1);
        issue(OP_TICK, '0, '0, 1'b0);
        issue(OP_TICK, '0, '0, 1'b0);
        for (int k = 1; k <= 8; k++)
            issue(OP_SET, ID_W'(1) << (k - 1), PER_W'(10 * k), k[0]);
        issue(OP_SET, 16'h8000, 24'd90, 1'b0);
        issue(OP_SET, 16'h0300, 24'd20, 1'b0);
        issue(OP_TICK, '0, '0, 1'b0);
        issue(OP_TICK, '0, '0, 1'b0);
        issue(OP_KILL, 16'h0102, '0, 1'b0);
        issue(OP_TICK, '0, '0, 1'b0);
        issue(OP_SET, 16'h5A5A, WRAP_AT, 1'b1);
        issue(OP_SET, 16'hA5A5, 24'd10, 1'b0);
        issue(OP_TICK, '0, '0, 1'b0);
        issue(OP_CLEAR, 16'hFFFF, 24'hFFFFFF, 1'b1);
        issue(OP_TICK, '0, '0, 1'b0);

        for (int n = 0; n < 410; n++)
        begin
            if (n == 137)
                send_idle_pct = 75;
            else if (n == 274)
                send_idle_pct = 0;
            random_item();
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (timers.expected_results.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (300) @(posedge clk);
        if (timers.mismatches == 0 && timers.expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
